// ===== hdl/stt_pkg.sv =====
// stt_pkg: item types, token kinds, scanner states and keyword table
// for the source text tokenizer; no dependencies
`default_nettype none

package stt_pkg;

  localparam int LINE_W = 24;
  localparam int KW_NUM = 11;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [5:0]        token_kind;
    logic [63:0]       int_value;
    logic [7:0]        text_byte;
    logic [LINE_W-1:0] line_number;
  } out_item_t;

  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } core_res_t;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b00_0000_0001,
    M_INT   = 10'b00_0000_0010,
    M_ID    = 10'b00_0000_0100,
    M_STR   = 10'b00_0000_1000,
    M_ESC   = 10'b00_0001_0000,
    M_OP    = 10'b00_0010_0000,
    M_LCOM  = 10'b00_0100_0000,
    M_BCOM  = 10'b00_1000_0000,
    M_BSTAR = 10'b01_0000_0000,
    M_ERR   = 10'b10_0000_0000
  } mode_t;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_INT     = 6'd1;
  localparam logic [5:0] K_STR     = 6'd2;
  localparam logic [5:0] K_ID      = 6'd3;
  localparam logic [5:0] K_KW0     = 6'd4;
  localparam logic [5:0] K_EQ_EQ   = 6'd15;
  localparam logic [5:0] K_NOT_EQ  = 6'd16;
  localparam logic [5:0] K_LESS_EQ = 6'd17;
  localparam logic [5:0] K_GRT_EQ  = 6'd18;
  localparam logic [5:0] K_DOTDOT  = 6'd19;
  localparam logic [5:0] K_LPAREN  = 6'd20;
  localparam logic [5:0] K_RPAREN  = 6'd21;
  localparam logic [5:0] K_LBRACE  = 6'd22;
  localparam logic [5:0] K_RBRACE  = 6'd23;
  localparam logic [5:0] K_LBRACK  = 6'd24;
  localparam logic [5:0] K_RBRACK  = 6'd25;
  localparam logic [5:0] K_COMMA   = 6'd26;
  localparam logic [5:0] K_DOT     = 6'd27;
  localparam logic [5:0] K_SEMI    = 6'd28;
  localparam logic [5:0] K_COLON   = 6'd29;
  localparam logic [5:0] K_PLUS    = 6'd30;
  localparam logic [5:0] K_MINUS   = 6'd31;
  localparam logic [5:0] K_STAR    = 6'd32;
  localparam logic [5:0] K_SLASH   = 6'd33;
  localparam logic [5:0] K_PCT     = 6'd34;
  localparam logic [5:0] K_ASSIGN  = 6'd35;
  localparam logic [5:0] K_LESS    = 6'd36;
  localparam logic [5:0] K_GRT     = 6'd37;
  localparam logic [5:0] K_BANG    = 6'd38;
  localparam logic [5:0] K_TEXT    = 6'd39;
  localparam logic [5:0] K_ERROR   = 6'd40;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_ASSIGN = 8'h3D;
  localparam logic [7:0] CH_GRT    = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keywords, right aligned, in kind order
  localparam logic [47:0] KW_WORD [KW_NUM] = '{
    48'h0000_006C_6574,  // let
    48'h6C65_7472_6563,  // letrec
    48'h0000_0000_666E,  // fn
    48'h0000_6E75_6C6C,  // null
    48'h0000_7472_7565,  // true
    48'h0066_616C_7365,  // false
    48'h0000_0000_6966,  // if
    48'h0000_656C_7365,  // else
    48'h0000_0061_6E64,  // and
    48'h0000_0000_6F72,  // or
    48'h0000_006E_6F74   // not
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd6, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd4, 3'd3, 3'd2, 3'd3
  };

  function automatic logic [5:0] kw_kind(input logic [2:0] len, input logic [47:0] win);
    logic [5:0] k;
    k = K_ID;
    for (int i = 0; i < KW_NUM; i++) begin
      if (len == KW_LEN[i] && win == KW_WORD[i]) begin
        k = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    logic hit;
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
      CH_COMMA, CH_DOT, CH_SEMI, CH_COLON, CH_PLUS, CH_MINUS, CH_STAR,
      CH_SLASH, CH_PCT, CH_ASSIGN, CH_LESS, CH_GRT, CH_BANG: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_LBRACK: k = K_LBRACK;
      CH_RBRACK: k = K_RBRACK;
      CH_COMMA:  k = K_COMMA;
      CH_DOT:    k = K_DOT;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_PCT:    k = K_PCT;
      CH_ASSIGN: k = K_ASSIGN;
      CH_LESS:   k = K_LESS;
      CH_GRT:    k = K_GRT;
      CH_BANG:   k = K_BANG;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic out_item_t mk_item(input logic [5:0] kind, input logic [63:0] val,
                                        input logic [7:0] tb, input logic [LINE_W-1:0] line);
    out_item_t o;
    o.token_kind  = kind;
    o.int_value   = val;
    o.text_byte   = tb;
    o.line_number = line;
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/source_text_tokenizer_top.sv =====
// source_text_tokenizer_top: input register, scanner and a four-entry result queue
// depends on stt_pkg and stt_core
`default_nettype none

// Streaming tokenizer: one source byte goes in per item and tokens come out as items,
// with identifier and string characters delivered as text-byte items ahead of their
// token. A byte is taken every cycle while the result queue holds at most two items.
// A byte that both closes a token and opens another yields two results, which the
// output side then takes one after the other; a run of such bytes or a stalled output
// fills the queue and raises in_stall until it drains. An accepted byte is held in
// the input register and scanned from there once the queue has room; its results
// are written into the result queue and show on out_valid from there.
// LINE_BITS sets the width of the saturating line counter; line_number carries its
// low 24 bits.

module source_text_tokenizer_top import stt_pkg::*; #(
  parameter int LINE_BITS = 24
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic       in_v_r;
  in_item_t   in_d_r;
  logic       room, go, pop;
  core_res_t  res;
  logic [1:0] push_n;

  out_item_t  q_mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign room      = cnt_r <= 3'd2;
  assign go        = in_v_r && room;
  assign in_stall  = in_v_r && !room;
  assign pop       = out_valid && !out_stall;
  assign push_n    = go ? res.cnt : 2'd0;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = q_mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_d_r <= in_data;
    end
  end

  stt_core #(
    .LINE_BITS(LINE_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (in_d_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wp_r] <= res.r0;
    end
    if (push_n == 2'd2) begin
      q_mem[wp_r + 2'd1] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_r + push_n;
      rp_r  <= rp_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stt_core.sv =====
// stt_core: scanner state and the per-byte token logic, up to two results per byte
// depends on stt_pkg
`default_nettype none

module stt_core import stt_pkg::*; #(
  parameter int LINE_BITS = 24
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      go,
  input  wire in_item_t  item,
  output core_res_t      res
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  mode_t                mode_r, mode_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [47:0]          win_r, win_nxt;
  logic [2:0]           len_r, len_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_BITS-1:0] start_r, start_nxt;

  logic        endm, dig, alpha, space, op_start, tail;
  logic [7:0]  c, dch;
  logic [63:0] dval;
  logic        p1_v, p2_v;
  out_item_t   p1, p2;
  logic [LINE_BITS-1:0] line_inc;

  function automatic logic [LINE_W-1:0] to_out(input logic [LINE_BITS-1:0] x);
    logic [LINE_BITS+LINE_W-1:0] e;
    e = {{LINE_W{1'b0}}, x};
    return e[LINE_W-1:0];
  endfunction

  assign c        = item.char_code;
  assign endm     = item.req_type | (c == 8'h00);
  assign dig      = (c >= CH_ZERO) && (c <= CH_NINE);
  assign alpha    = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  assign space    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign op_start = (c == CH_ASSIGN) || (c == CH_BANG) || (c == CH_LESS) || (c == CH_GRT) ||
                    (c == CH_DOT) || (c == CH_PLUS) || (c == CH_SLASH);
  assign dval     = {56'b0, c - CH_ZERO};
  assign line_inc = (line_r != LINE_MAX) ? line_r + LINE_ONE : line_r;
  assign dch      = (c == CH_LO_N) ? CH_LF : ((c == CH_LO_T) ? CH_TAB : c);

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    win_nxt   = win_r;
    len_nxt   = len_r;
    line_nxt  = line_r;
    start_nxt = start_r;
    p1_v      = 1'b0;
    p2_v      = 1'b0;
    p1        = '0;
    p2        = '0;
    tail      = 1'b0;

    case (mode_r)
      M_INT: begin
        if (!endm && dig) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1) + dval;
        end else begin
          p1_v     = 1'b1;
          p1       = mk_item(K_INT, acc_r, 8'h00, to_out(start_r));
          mode_nxt = M_IDLE;
          tail     = 1'b1;
        end
      end
      M_ID: begin
        if (!endm && (alpha || dig || c == CH_UNDER || c == CH_QMARK)) begin
          if (len_r < 3'd6) begin
            win_nxt = {win_r[39:0], c};
          end
          if (len_r < 3'd7) begin
            len_nxt = len_r + 3'd1;
          end
          p1_v = 1'b1;
          p1   = mk_item(K_TEXT, 64'd0, c, to_out(start_r));
        end else begin
          p1_v     = 1'b1;
          p1       = mk_item(kw_kind(len_r, win_r), 64'd0, 8'h00, to_out(start_r));
          mode_nxt = M_IDLE;
          tail     = 1'b1;
        end
      end
      M_STR: begin
        if (!endm && c == CH_BSLASH) begin
          mode_nxt = M_ESC;
        end else if (!endm && c != CH_QUOTE) begin
          p1_v = 1'b1;
          p1   = mk_item(K_TEXT, 64'd0, c, to_out(start_r));
        end else begin
          p1_v     = 1'b1;
          p1       = mk_item(K_STR, 64'd0, 8'h00, to_out(start_r));
          mode_nxt = M_IDLE;
          tail     = endm;
        end
      end
      M_ESC: begin
        p1_v = 1'b1;
        if (!endm) begin
          p1       = mk_item(K_TEXT, 64'd0, dch, to_out(start_r));
          mode_nxt = M_STR;
        end else begin
          p1       = mk_item(K_STR, 64'd0, 8'h00, to_out(start_r));
          mode_nxt = M_IDLE;
          tail     = 1'b1;
        end
      end
      M_OP: begin
        mode_nxt = M_IDLE;
        p1_v     = 1'b1;
        p1       = mk_item(single_kind(pend_r), 64'd0, 8'h00, to_out(start_r));
        if (!endm && c == CH_ASSIGN && pend_r == CH_ASSIGN) begin
          p1.token_kind = K_EQ_EQ;
        end else if (!endm && c == CH_ASSIGN && pend_r == CH_BANG) begin
          p1.token_kind = K_NOT_EQ;
        end else if (!endm && c == CH_ASSIGN && pend_r == CH_LESS) begin
          p1.token_kind = K_LESS_EQ;
        end else if (!endm && c == CH_ASSIGN && pend_r == CH_GRT) begin
          p1.token_kind = K_GRT_EQ;
        end else if (!endm && c == CH_DOT && pend_r == CH_DOT) begin
          p1.token_kind = K_DOTDOT;
        end else if (!endm && c == CH_PLUS && pend_r == CH_PLUS) begin
          p1.token_kind = K_PLUS;
        end else if (!endm && c == CH_SLASH && pend_r == CH_SLASH) begin
          p1_v     = 1'b0;
          mode_nxt = M_LCOM;
        end else if (!endm && c == CH_STAR && pend_r == CH_SLASH) begin
          p1_v     = 1'b0;
          mode_nxt = M_BCOM;
        end else begin
          tail = 1'b1;
        end
      end
      M_LCOM: begin
        if (endm || c == CH_LF) begin
          mode_nxt = M_IDLE;
          tail     = 1'b1;
        end
      end
      M_BCOM, M_BSTAR: begin
        if (endm) begin
          mode_nxt = M_IDLE;
          tail     = 1'b1;
        end else if (mode_r == M_BSTAR && c == CH_SLASH) begin
          mode_nxt = M_IDLE;
        end else begin
          if (c == CH_LF) begin
            line_nxt = line_inc;
          end
          mode_nxt = (c == CH_STAR) ? M_BSTAR : M_BCOM;
        end
      end
      M_ERR: begin
        tail = endm;
      end
      default: begin
        mode_nxt = M_IDLE;
        tail     = 1'b1;
      end
    endcase

    if (tail) begin
      if (endm) begin
        p2_v      = 1'b1;
        p2        = mk_item(K_EOF, 64'd0, 8'h00, to_out(line_r));
        mode_nxt  = M_IDLE;
        pend_nxt  = 8'h00;
        acc_nxt   = 64'd0;
        win_nxt   = 48'd0;
        len_nxt   = 3'd0;
        line_nxt  = LINE_ONE;
        start_nxt = LINE_ONE;
      end else if (space) begin
        if (c == CH_LF) begin
          line_nxt = line_inc;
        end
      end else begin
        start_nxt = line_r;
        if (dig) begin
          mode_nxt = M_INT;
          acc_nxt  = dval;
        end else if (alpha || c == CH_UNDER) begin
          mode_nxt = M_ID;
          win_nxt  = {40'd0, c};
          len_nxt  = 3'd1;
          p2_v     = 1'b1;
          p2       = mk_item(K_TEXT, 64'd0, c, to_out(line_r));
        end else if (c == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else if (op_start) begin
          mode_nxt = M_OP;
          pend_nxt = c;
        end else if (is_single(c)) begin
          p2_v = 1'b1;
          p2   = mk_item(single_kind(c), 64'd0, 8'h00, to_out(line_r));
        end else begin
          mode_nxt = M_ERR;
          p2_v     = 1'b1;
          p2       = mk_item(K_ERROR, 64'd0, 8'h00, to_out(line_r));
        end
      end
    end

    res.cnt = {1'b0, p1_v} + {1'b0, p2_v};
    res.r0  = p1_v ? p1 : p2;
    res.r1  = p2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pend_r  <= 8'h00;
      acc_r   <= 64'd0;
      win_r   <= 48'd0;
      len_r   <= 3'd0;
      line_r  <= LINE_ONE;
      start_r <= LINE_ONE;
    end else if (go) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      win_r   <= win_nxt;
      len_r   <= len_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stt_checker.sv =====
// stt_checker: port-level checks on the tokenizer's channels and reset
// depends on stt_pkg; bound to source_text_tokenizer_top
`default_nettype none

module stt_checker import stt_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  a_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind != K_TEXT |-> out_data.text_byte == 8'h00)
    else $error("text byte set on a non-text item");

  a_int_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind != K_INT |-> out_data.int_value == 64'd0)
    else $error("int value set on a non-int item");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);

`default_nettype wire
